// ===== hw/rtl/scpa_pkg.sv =====
// types, constants and the micro-program of the serial chain pose accumulator
// used by the core, mac and cordic modules (not by the ram), depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

    localparam int JOINT_WORDS   = 10;
    localparam int SCRATCH_WORDS = 48;
    localparam int PROG_LEN      = 109;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sh0_26DD_3B6A;

    // operand codes: scratch words below A_OFF, per-joint words from A_OFF up
    localparam logic [5:0] A_R   = 6'd0;
    localparam logic [5:0] A_T   = 6'd9;
    localparam logic [5:0] A_RQ  = 6'd12;
    localparam logic [5:0] A_RA  = 6'd21;
    localparam logic [5:0] A_TMP = 6'd30;
    localparam logic [5:0] A_K   = 6'd39;
    localparam logic [5:0] A_SA  = 6'd42;
    localparam logic [5:0] A_C   = 6'd45;
    localparam logic [5:0] A_S   = 6'd46;
    localparam logic [5:0] A_OMC = 6'd47;
    localparam logic [5:0] A_OFF = 6'd48;
    localparam logic [5:0] A_QW  = 6'd51;
    localparam logic [5:0] A_QX  = 6'd52;
    localparam logic [5:0] A_QY  = 6'd53;
    localparam logic [5:0] A_QZ  = 6'd54;
    localparam logic [5:0] A_AX  = 6'd55;
    localparam logic [5:0] QUAT_LOAD_WORDS = 6'd7;

    localparam logic [1:0] MODE_ORIGIN = 2'd0;
    localparam logic [1:0] MODE_AXIS   = 2'd1;
    localparam logic [1:0] MODE_ANGLE  = 2'd2;

    localparam logic [6:0] F_NONE  = 7'b0000000;
    localparam logic [6:0] F_ONE   = 7'b1000000;
    localparam logic [6:0] F_NEG   = 7'b0100000;
    localparam logic [6:0] F_DBL   = 7'b0010000;
    localparam logic [6:0] F_FIRST = 7'b0001000;
    localparam logic [6:0] F_BASE1 = 7'b0000100;
    localparam logic [6:0] F_LAST  = 7'b0000010;
    localparam logic [6:0] F_FENCE = 7'b0000001;

    typedef struct packed {
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] dst;
        logic       b_one;
        logic       neg;
        logic       dbl;
        logic       first;
        logic       base_one;
        logic       last;
        logic       fence;
    } uop_t;

    typedef struct packed {
        logic              en;
        logic [5:0]        dst;
        logic signed [31:0] data;
    } mac_wr_t;

    function automatic uop_t mk(input logic [5:0] a, input logic [5:0] b,
                                input logic [5:0] dst, input logic [6:0] f);
        uop_t u;
        u.a        = a;
        u.b        = b;
        u.dst      = dst;
        u.b_one    = f[6];
        u.neg      = f[5];
        u.dbl      = f[4];
        u.first    = f[3];
        u.base_one = f[2];
        u.last     = f[1];
        u.fence    = f[0];
        return u;
    endfunction

    function automatic uop_t uop_at(input logic [6:0] idx);
        uop_t u;
        logic [6:0] fl;
        u = mk(A_C, A_C, A_C, F_NONE);
        case (idx)
            // quaternion matrix
            7'd0:  u = mk(A_QY, A_QY, A_RQ, F_NEG | F_DBL | F_FIRST | F_BASE1);
            7'd1:  u = mk(A_QZ, A_QZ, A_RQ, F_NEG | F_DBL | F_LAST);
            7'd2:  u = mk(A_QX, A_QY, A_RQ + 6'd1, F_DBL | F_FIRST);
            7'd3:  u = mk(A_QW, A_QZ, A_RQ + 6'd1, F_NEG | F_DBL | F_LAST);
            7'd4:  u = mk(A_QX, A_QZ, A_RQ + 6'd2, F_DBL | F_FIRST);
            7'd5:  u = mk(A_QW, A_QY, A_RQ + 6'd2, F_DBL | F_LAST);
            7'd6:  u = mk(A_QX, A_QY, A_RQ + 6'd3, F_DBL | F_FIRST);
            7'd7:  u = mk(A_QW, A_QZ, A_RQ + 6'd3, F_DBL | F_LAST);
            7'd8:  u = mk(A_QX, A_QX, A_RQ + 6'd4, F_NEG | F_DBL | F_FIRST | F_BASE1);
            7'd9:  u = mk(A_QZ, A_QZ, A_RQ + 6'd4, F_NEG | F_DBL | F_LAST);
            7'd10: u = mk(A_QY, A_QZ, A_RQ + 6'd5, F_DBL | F_FIRST);
            7'd11: u = mk(A_QW, A_QX, A_RQ + 6'd5, F_NEG | F_DBL | F_LAST);
            7'd12: u = mk(A_QX, A_QZ, A_RQ + 6'd6, F_DBL | F_FIRST);
            7'd13: u = mk(A_QW, A_QY, A_RQ + 6'd6, F_NEG | F_DBL | F_LAST);
            7'd14: u = mk(A_QY, A_QZ, A_RQ + 6'd7, F_DBL | F_FIRST);
            7'd15: u = mk(A_QW, A_QX, A_RQ + 6'd7, F_DBL | F_LAST);
            7'd16: u = mk(A_QX, A_QX, A_RQ + 6'd8, F_NEG | F_DBL | F_FIRST | F_BASE1);
            7'd17: u = mk(A_QY, A_QY, A_RQ + 6'd8, F_NEG | F_DBL | F_LAST);
            // one minus cosine, then k and s times axis
            7'd18: u = mk(A_C, A_C, A_OMC,
                          F_ONE | F_NEG | F_FIRST | F_BASE1 | F_LAST | F_FENCE);
            7'd19: u = mk(A_OMC, A_AX, A_K, F_FIRST | F_LAST);
            7'd20: u = mk(A_OMC, A_AX + 6'd1, A_K + 6'd1, F_FIRST | F_LAST);
            7'd21: u = mk(A_OMC, A_AX + 6'd2, A_K + 6'd2, F_FIRST | F_LAST);
            7'd22: u = mk(A_S, A_AX, A_SA, F_FIRST | F_LAST);
            7'd23: u = mk(A_S, A_AX + 6'd1, A_SA + 6'd1, F_FIRST | F_LAST);
            7'd24: u = mk(A_S, A_AX + 6'd2, A_SA + 6'd2, F_FIRST | F_LAST | F_FENCE);
            // axis-angle matrix
            7'd25: u = mk(A_K, A_AX, A_RA, F_FIRST);
            7'd26: u = mk(A_C, A_C, A_RA, F_ONE | F_LAST);
            7'd27: u = mk(A_K + 6'd1, A_AX + 6'd1, A_RA + 6'd4, F_FIRST);
            7'd28: u = mk(A_C, A_C, A_RA + 6'd4, F_ONE | F_LAST);
            7'd29: u = mk(A_K + 6'd2, A_AX + 6'd2, A_RA + 6'd8, F_FIRST);
            7'd30: u = mk(A_C, A_C, A_RA + 6'd8, F_ONE | F_LAST);
            7'd31: u = mk(A_K, A_AX + 6'd1, A_RA + 6'd1, F_FIRST);
            7'd32: u = mk(A_SA + 6'd2, A_C, A_RA + 6'd1, F_ONE | F_NEG | F_LAST);
            7'd33: u = mk(A_K, A_AX + 6'd1, A_RA + 6'd3, F_FIRST);
            7'd34: u = mk(A_SA + 6'd2, A_C, A_RA + 6'd3, F_ONE | F_LAST);
            7'd35: u = mk(A_K, A_AX + 6'd2, A_RA + 6'd2, F_FIRST);
            7'd36: u = mk(A_SA + 6'd1, A_C, A_RA + 6'd2, F_ONE | F_LAST);
            7'd37: u = mk(A_K, A_AX + 6'd2, A_RA + 6'd6, F_FIRST);
            7'd38: u = mk(A_SA + 6'd1, A_C, A_RA + 6'd6, F_ONE | F_NEG | F_LAST);
            7'd39: u = mk(A_K + 6'd1, A_AX + 6'd2, A_RA + 6'd5, F_FIRST);
            7'd40: u = mk(A_SA, A_C, A_RA + 6'd5, F_ONE | F_NEG | F_LAST);
            7'd41: u = mk(A_K + 6'd1, A_AX + 6'd2, A_RA + 6'd7, F_FIRST);
            7'd42: u = mk(A_SA, A_C, A_RA + 6'd7, F_ONE | F_LAST);
            default: ;
        endcase
        // translation with the old rotation
        for (int r = 0; r < 3; r++)
        begin
            if (idx == 7'(43 + 4 * r))
                u = mk(6'(A_T + r), A_C, 6'(A_T + r), F_ONE | F_FIRST);
            for (int i = 0; i < 3; i++)
            begin
                if (idx == 7'(44 + 4 * r + i))
                    u = mk(6'(A_R + 3 * r + i), 6'(A_OFF + i), 6'(A_T + r),
                           (i == 2) ? F_LAST : F_NONE);
            end
        end
        // pose times quaternion matrix, then times axis matrix
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    fl = (k == 0) ? F_FIRST : ((k == 2) ? F_LAST : F_NONE);
                    if (r == 2 && c == 2 && k == 2)
                        fl = fl | F_FENCE;
                    if (idx == 7'(55 + 9 * r + 3 * c + k))
                        u = mk(6'(A_R + 3 * r + k), 6'(A_RQ + 3 * k + c),
                               6'(A_TMP + 3 * r + c), fl);
                    if (idx == 7'(82 + 9 * r + 3 * c + k))
                        u = mk(6'(A_TMP + 3 * r + k), 6'(A_RA + 3 * k + c),
                               6'(A_R + 3 * r + c), fl);
                end
            end
        end
        return u;
    endfunction

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] o;
        if (v > 40'sd2147483647)
            o = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            o = 32'sh8000_0000;
        else
            o = v[31:0];
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_chain_pose_accumulator_core.sv =====
// serial chain pose accumulator, top level: sequencer, data ram, mac and cordic
// depends on scpa_pkg, scpa_ram, scpa_mac, scpa_cordic
// one item at a time; s_tready is high only while idle
// origin load item writes seven joint words, axis load item writes three, an ignored item is dropped
// angle item: the first row follows the cordic loop and the shared multiplier (109 products,
//   4 drains), after an identity pass of the pose on a restart
// reset: pose is set to identity by the first angle item, joint tables are undefined until loaded, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module serial_chain_pose_accumulator_core
    import scpa_pkg::*;
#(
    parameter int MAX_JOINTS   = 8,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // joint_index, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z, angle, zero fill
    input  wire logic [263:0] s_tdata,
    // mode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_joint, row_index, rot_col0, rot_col1, rot_col2, trans, zero fill
    output logic [135:0]      m_tdata,
    output logic              m_tlast
);

    localparam int DEPTH    = MAX_JOINTS * JOINT_WORDS + SCRATCH_WORDS;
    localparam int AW       = $clog2(DEPTH);
    localparam int SCR_BASE = MAX_JOINTS * JOINT_WORDS;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_LOAD   = 13'b0000000000010,
        S_IDENT  = 13'b0000000000100,
        S_CSTART = 13'b0000000001000,
        S_CORDIC = 13'b0000000010000,
        S_WRC    = 13'b0000000100000,
        S_WRS    = 13'b0000001000000,
        S_PROG   = 13'b0000010000000,
        S_FENCE  = 13'b0000100000000,
        S_ORD0   = 13'b0001000000000,
        S_ORD1   = 13'b0010000000000,
        S_ORD2   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg;
    logic [6:0]         step_reg;
    logic [1:0]         row_reg;
    logic               pose_init_reg;
    logic               quat_load_reg;
    logic [2:0]         joint_reg;
    logic signed [31:0] word_reg [7];
    logic signed [31:0] angle_reg;
    logic               issue_valid_reg;
    uop_t               issue_op_reg;
    logic signed [31:0] col0_reg, col1_reg;

    logic [2:0]         in_joint;
    logic               accept, ignore;
    uop_t               cur_op;
    logic [AW-1:0]      joint_base;
    logic               we;
    logic [AW-1:0]      waddr, raddr_a, raddr_b;
    logic [31:0]        wdata, rdata_a, rdata_b;
    logic [AW-1:0]      row_base;
    logic signed [31:0] mac_b;
    mac_wr_t            mac_wr;
    logic               mac_busy;
    logic               cordic_start, cordic_done;
    logic signed [31:0] cos_val, sin_val;
    logic               load_end;

    function automatic logic [AW-1:0] map_code(input logic [5:0] code,
                                               input logic [AW-1:0] jbase);
        logic [AW-1:0] ad;
        if (code >= A_OFF)
            ad = jbase + AW'(code - A_OFF);
        else
            ad = AW'(SCR_BASE) + AW'(code);
        return ad;
    endfunction

    assign in_joint   = s_tdata[2:0];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign ignore     = (32'(in_joint) >= MAX_JOINTS) || (s_tuser != MODE_ORIGIN
                        && s_tuser != MODE_AXIS && s_tuser != MODE_ANGLE);
    assign cur_op     = uop_at(step_reg);
    assign joint_base = AW'(joint_reg) * AW'(JOINT_WORDS);
    assign row_base   = AW'(SCR_BASE) + AW'(row_reg) * AW'(3);
    assign mac_b      = issue_op_reg.b_one ? ONE_Q30 : signed'(rdata_b);
    assign cordic_start = (state_reg == S_CSTART);
    assign load_end   = quat_load_reg ? (cnt_reg == 4'(QUAT_LOAD_WORDS - 6'd1))
                                      : (cnt_reg == 4'd2);

    always_comb
    begin
        we    = 1'b0;
        waddr = map_code(mac_wr.dst, joint_base);
        wdata = mac_wr.data;
        case (state_reg)
            S_LOAD:
            begin
                we    = 1'b1;
                waddr = joint_base + (quat_load_reg ? AW'(cnt_reg)
                                                    : AW'(cnt_reg) + AW'(QUAT_LOAD_WORDS));
                wdata = word_reg[cnt_reg[2:0]];
            end
            S_IDENT:
            begin
                we    = 1'b1;
                waddr = AW'(SCR_BASE) + AW'(cnt_reg);
                wdata = (cnt_reg inside {4'd0, 4'd4, 4'd8}) ? ONE_Q30 : 32'd0;
            end
            S_WRC:
            begin
                we    = 1'b1;
                waddr = map_code(A_C, joint_base);
                wdata = cos_val;
            end
            S_WRS:
            begin
                we    = 1'b1;
                waddr = map_code(A_S, joint_base);
                wdata = sin_val;
            end
            default:
            begin
                we = mac_wr.en;
            end
        endcase
    end

    always_comb
    begin
        raddr_a = map_code(cur_op.a, joint_base);
        raddr_b = map_code(cur_op.b, joint_base);
        case (state_reg)
            S_ORD0:
            begin
                raddr_a = row_base;
                raddr_b = row_base + AW'(1);
            end
            S_ORD1:
            begin
                raddr_a = row_base + AW'(2);
                raddr_b = AW'(SCR_BASE) + AW'(A_T) + AW'(row_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !ignore)
                begin
                    if (s_tuser == MODE_ANGLE)
                        state_next = (in_joint == 3'd0 || !pose_init_reg) ? S_IDENT
                                                                          : S_CSTART;
                    else
                        state_next = S_LOAD;
                end
            end
            S_LOAD:   if (load_end) state_next = S_IDLE;
            S_IDENT:  if (cnt_reg == 4'd11) state_next = S_CSTART;
            S_CSTART: state_next = S_CORDIC;
            S_CORDIC: if (cordic_done) state_next = S_WRC;
            S_WRC:    state_next = S_WRS;
            S_WRS:    state_next = S_PROG;
            S_PROG:   if (cur_op.fence) state_next = S_FENCE;
            S_FENCE:
            begin
                if (!issue_valid_reg && !mac_busy)
                    state_next = (step_reg == 7'(PROG_LEN)) ? S_ORD0 : S_PROG;
            end
            S_ORD0:   state_next = S_ORD1;
            S_ORD1:   state_next = S_ORD2;
            S_ORD2:   state_next = S_OUT;
            S_OUT:
            begin
                if (m_tready)
                    state_next = (row_reg == 2'd2) ? S_IDLE : S_ORD0;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= 4'd0;
            step_reg        <= 7'd0;
            row_reg         <= 2'd0;
            pose_init_reg   <= 1'b0;
            issue_valid_reg <= 1'b0;
            m_tvalid        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_valid_reg <= (state_reg == S_PROG);
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg  <= 4'd0;
                    step_reg <= 7'd0;
                    row_reg  <= 2'd0;
                end
                S_LOAD:  cnt_reg <= cnt_reg + 4'd1;
                S_IDENT:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd11)
                        pose_init_reg <= 1'b1;
                end
                S_PROG:  step_reg <= step_reg + 7'd1;
                S_ORD2:  m_tvalid <= 1'b1;
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        m_tvalid <= 1'b0;
                        row_reg  <= row_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quat_load_reg <= (s_tuser == MODE_ORIGIN);
            joint_reg     <= in_joint;
            word_reg[0]   <= s_tdata[34:3];
            word_reg[1]   <= s_tdata[66:35];
            word_reg[2]   <= s_tdata[98:67];
            word_reg[3]   <= s_tdata[130:99];
            word_reg[4]   <= s_tdata[162:131];
            word_reg[5]   <= s_tdata[194:163];
            word_reg[6]   <= s_tdata[226:195];
            angle_reg     <= s_tdata[258:227];
        end
        if (state_reg == S_PROG)
            issue_op_reg <= cur_op;
        if (state_reg == S_ORD1)
        begin
            col0_reg <= rdata_a;
            col1_reg <= rdata_b;
        end
        if (state_reg == S_ORD2)
        begin
            m_tdata <= {3'd0, rdata_b, rdata_a, col1_reg, col0_reg, row_reg, joint_reg};
            m_tlast <= (row_reg == 2'd2);
        end
    end

    scpa_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    scpa_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (issue_valid_reg),
        .in_op    (issue_op_reg),
        .a        (signed'(rdata_a)),
        .b        (mac_b),
        .wr       (mac_wr),
        .busy     (mac_busy)
    );

    scpa_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (angle_reg),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/scpa_ram.sv =====
// generic ram, one write port and two registered read ports
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module scpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scpa_mac.sv =====
// shared multiply, round and accumulate unit with saturating write-back
// depends on scpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module scpa_mac
    import scpa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire uop_t               in_op,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output mac_wr_t                 wr,
    output logic                    busy
);

    logic               v2_reg, v3_reg;
    uop_t               op2_reg, op3_reg;
    logic signed [63:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic signed [63:0] rnd;
    logic signed [33:0] shq;
    logic signed [39:0] term, base, acc_next;

    always_comb
    begin
        rnd  = prod_reg + 64'sd536870912;
        shq  = rnd[63:30];
        term = op2_reg.dbl ? {{5{shq[33]}}, shq, 1'b0} : {{6{shq[33]}}, shq};
        if (op2_reg.neg)
            term = -term;
        if (op2_reg.first)
            base = op2_reg.base_one ? 40'(ONE_Q30) : 40'sd0;
        else
            base = acc_reg;
        acc_next = base + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= a * b;
            op2_reg  <= in_op;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_next;
            op3_reg <= op2_reg;
        end
    end

    assign wr.en   = v3_reg & op3_reg.last;
    assign wr.dst  = op3_reg.dst;
    assign wr.data = sat40(acc_reg);
    assign busy    = v2_reg | v3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scpa_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on scpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module scpa_cordic
    import scpa_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] angle,
    output logic                    done,
    output logic signed [31:0]      cos_val,
    output logic signed [31:0]      sin_val
);

    logic               busy_reg;
    logic [4:0]         i_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] z0, xs, ys, xf, yf;

    always_comb
    begin
        z0 = 34'(angle) <<< 1;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            i_reg    <= 5'd0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= 5'd0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= GAIN_Q30;
            y_reg <= 34'sd0;
            if (z0 > HALF_PI_Q30)
            begin
                z_reg   <= z0 - PI_Q30;
                neg_reg <= 1'b1;
            end
            else if (z0 < -HALF_PI_Q30)
            begin
                z_reg   <= z0 + PI_Q30;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= z0;
                neg_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 34'(atan_q30(i_reg));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 34'(atan_q30(i_reg));
            end
        end
    end

    assign cos_val = sat40(40'(xf));
    assign sin_val = sat40(40'(yf));

endmodule

`default_nettype wire
